// ----- hw/rtl/sth_pkg.sv -----
// Shared constants, types and helpers for the symbol transition histogram.
// No dependencies; imported by the top level and its checker.
package sth_pkg;

  localparam int HISTORY_DEPTH   = 4096;
  localparam int MAX_SYMBOL_BITS = 3;

  localparam int HIST_AW    = $clog2(HISTORY_DEPTH);
  localparam int LEN_W      = $clog2(HISTORY_DEPTH + 1);
  localparam int PAIR_AW    = 2 * MAX_SYMBOL_BITS;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;
  localparam int EB_W       = $clog2(MAX_SYMBOL_BITS + 1);

  localparam int SYM_W   = 3;
  localparam int CNT_W   = 12;
  localparam int INT_W   = 8;
  localparam int NUM_W   = CNT_W + INT_W;
  localparam int STEP_W  = $clog2(INT_W);
  localparam int SB_W    = 2;
  localparam int HL_W    = 13;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [SB_W-1:0]  SB_RESET  = 2'd2;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [HIST_AW-1:0]         addr_t;
  typedef logic [PAIR_AW-1:0]         key_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [EB_W-1:0]            ebits_t;
  typedef logic [MAX_SYMBOL_BITS-1:0] sym_t;
  typedef logic [NUM_W-1:0]           num_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    REG_SYMBOL_BITS = 1'b0,
    REG_HISTORY_LEN = 1'b1
  } reg_idx_t;

  function automatic len_t clamp_len(input logic [HL_W-1:0] v);
    len_t r;
    if (v == '0) begin
      r = len_t'(1);
    end else if (32'(v) > HISTORY_DEPTH) begin
      r = len_t'(HISTORY_DEPTH);
    end else begin
      r = len_t'(v);
    end
    return r;
  endfunction

  function automatic ebits_t eff_bits(input logic [SB_W-1:0] sb);
    ebits_t r;
    if (32'(sb) > MAX_SYMBOL_BITS) begin
      r = ebits_t'(MAX_SYMBOL_BITS);
    end else begin
      r = ebits_t'(sb);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/symbol_transition_histogram.sv -----
// Push: one request per cycle while busy is low, busy stays low. Readout of F stored symbols
// over S = 2^symbol_bits states: walk through the history memory, drain the pipeline,
// then per matrix entry a count memory read plus an 8-step divider, giving one result
// per entry. Readout with F below 2 is not accepted: busy stays low, no result.
// Reset (rst_n, synchronous): registers to defaults, fill and pointer zero; history undefined.
// Depends on sth_pkg.
module symbol_transition_histogram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [sth_pkg::SYM_W-1:0]     in_symbol,
  output logic                          out_strobe,
  output logic [sth_pkg::SYM_W-1:0]     out_from_symbol,
  output logic [sth_pkg::SYM_W-1:0]     out_to_symbol,
  output logic [sth_pkg::CNT_W-1:0]     out_pair_count,
  output logic [sth_pkg::INT_W-1:0]     out_intensity,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sth_pkg::CFG_AW-1:0]    paddr,
  input  logic [sth_pkg::CFG_DW-1:0]    pwdata,
  output logic [sth_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import sth_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_EM_RD,
    S_EM_LD,
    S_EM_DIV
  } state_t;

  state_t state_r;

  logic [SB_W-1:0] sym_bits_r;
  len_t            hist_len_r;
  addr_t           wp_r;
  len_t            fill_r;

  logic [SYM_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [SYM_W-1:0] hist_rdata_r;
  cnt_t             pair_mem [PAIR_DEPTH];
  cnt_t             pair_rdata_r;
  logic [PAIR_DEPTH-1:0] pair_vld_r;

  addr_t  rd_pos_r;
  len_t   rd_cnt_r;
  logic   walk_first_r;
  logic   b_vld_r;
  logic   b_first_r;
  sym_t   prev_r;
  logic   c_vld_r;
  key_t   c_k_r;
  logic   lw_vld_r;
  key_t   lw_k_r;
  cnt_t   lw_cnt_r;
  cnt_t   max_r;

  key_t                ek_r;
  cnt_t                em_cnt_r;
  num_t                num_r;
  num_t                den_r;
  logic [INT_W-1:0]    q_r;
  logic [STEP_W-1:0]   step_r;

  logic                out_strobe_r;
  logic [SYM_W-1:0]    out_from_r;
  logic [SYM_W-1:0]    out_to_r;
  cnt_t                out_cnt_r;
  logic [INT_W-1:0]    out_int_r;
  logic                out_last_r;

  logic   cfg_wr;
  logic   acc;
  logic   push;
  logic   rd_go;
  ebits_t eb;
  sym_t   mask;
  sym_t   cur;
  key_t   b_k;
  key_t   pair_raddr;
  key_t   last_k;
  len_t   wp_inc;
  len_t   pos_inc;
  len_t   start_pos;
  cnt_t   cnt_old;
  cnt_t   cnt_new;
  cnt_t   em_cnt;
  logic   div_ge;
  logic [INT_W-1:0] q_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign busy   = (state_r != S_IDLE);
  assign acc    = start & ~busy;
  assign push   = acc & (in_operation == OP_PUSH);
  assign rd_go  = acc & (in_operation == OP_READ) & (fill_r >= len_t'(2));

  assign eb     = eff_bits(sym_bits_r);
  assign mask   = sym_t'((32'd1 << eb) - 32'd1);
  assign last_k = key_t'(((32'd1 << {eb, 1'b0})) - 32'd1);
  assign cur    = sym_t'(hist_rdata_r) & mask;
  assign b_k    = (key_t'(prev_r) << eb) | key_t'(cur);
  assign pair_raddr = (state_r == S_EM_RD) ? ek_r : b_k;

  assign wp_inc    = len_t'(wp_r) + len_t'(1);
  assign pos_inc   = len_t'(rd_pos_r) + len_t'(1);
  assign start_pos = (len_t'(wp_r) >= fill_r) ? len_t'(wp_r) - fill_r
                                              : len_t'(wp_r) + hist_len_r - fill_r;

  always_comb begin
    if (lw_vld_r && (lw_k_r == c_k_r)) begin
      cnt_old = lw_cnt_r;
    end else if (pair_vld_r[c_k_r]) begin
      cnt_old = pair_rdata_r;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + cnt_t'(1);
  end

  assign em_cnt = pair_vld_r[ek_r] ? pair_rdata_r : '0;
  assign div_ge = (num_r >= den_r);
  assign q_nxt  = {q_r[INT_W-2:0], div_ge};

  always_comb begin
    unique case (reg_idx_t'(paddr[CFG_AW-1]))
      REG_SYMBOL_BITS: prdata = CFG_DW'(sym_bits_r);
      REG_HISTORY_LEN: prdata = CFG_DW'(hist_len_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hist_mem[wp_r] <= in_symbol;
    end
    hist_rdata_r <= hist_mem[rd_pos_r];
  end

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      pair_mem[c_k_r] <= cnt_new;
    end
    pair_rdata_r <= pair_mem[pair_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= SB_RESET;
      hist_len_r <= len_t'(HISTORY_DEPTH);
      wp_r       <= '0;
      fill_r     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[CFG_AW-1]))
        REG_SYMBOL_BITS: sym_bits_r <= pwdata[SB_W-1:0];
        REG_HISTORY_LEN: begin
          hist_len_r <= clamp_len(pwdata[HL_W-1:0]);
          wp_r       <= '0;
          fill_r     <= '0;
        end
        default: ;
      endcase
    end else if (push) begin
      wp_r <= (wp_inc >= hist_len_r) ? '0 : addr_t'(wp_inc);
      if (fill_r < hist_len_r) begin
        fill_r <= fill_r + len_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pair_vld_r   <= '0;
      walk_first_r <= 1'b0;
      b_vld_r      <= 1'b0;
      c_vld_r      <= 1'b0;
      lw_vld_r     <= 1'b0;
      max_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      b_vld_r      <= (state_r == S_WALK);
      c_vld_r      <= b_vld_r & ~b_first_r;
      lw_vld_r     <= c_vld_r;
      if (b_vld_r) begin
        prev_r <= cur;
      end
      c_k_r <= b_k;
      if (c_vld_r) begin
        pair_vld_r[c_k_r] <= 1'b1;
        lw_k_r            <= c_k_r;
        lw_cnt_r          <= cnt_new;
        if (cnt_new > max_r) begin
          max_r <= cnt_new;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (rd_go) begin
            pair_vld_r   <= '0;
            max_r        <= '0;
            rd_pos_r     <= addr_t'(start_pos);
            rd_cnt_r     <= fill_r;
            walk_first_r <= 1'b1;
            state_r      <= S_WALK;
          end
        end
        S_WALK: begin
          b_first_r    <= walk_first_r;
          walk_first_r <= 1'b0;
          rd_pos_r     <= (pos_inc == hist_len_r) ? '0 : addr_t'(pos_inc);
          rd_cnt_r     <= rd_cnt_r - len_t'(1);
          if (rd_cnt_r == len_t'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!b_vld_r && !c_vld_r) begin
            ek_r    <= '0;
            state_r <= S_EM_RD;
          end
        end
        S_EM_RD: begin
          state_r <= S_EM_LD;
        end
        S_EM_LD: begin
          em_cnt_r <= em_cnt;
          num_r    <= num_t'({em_cnt, INT_W'(0)}) - num_t'(em_cnt);
          den_r    <= num_t'({max_r, (INT_W - 1)'(0)});
          q_r      <= '0;
          step_r   <= STEP_W'(INT_W - 1);
          state_r  <= S_EM_DIV;
        end
        S_EM_DIV: begin
          q_r   <= q_nxt;
          den_r <= den_r >> 1;
          if (div_ge) begin
            num_r <= num_r - den_r;
          end
          if (step_r == '0) begin
            out_strobe_r <= 1'b1;
            out_from_r   <= SYM_W'(ek_r >> eb);
            out_to_r     <= SYM_W'(ek_r & key_t'(mask));
            out_cnt_r    <= em_cnt_r;
            out_int_r    <= (max_r == '0) ? '0 : q_nxt;
            out_last_r   <= (ek_r == last_k);
            if (ek_r == last_k) begin
              state_r <= S_IDLE;
            end else begin
              ek_r    <= ek_r + key_t'(1);
              state_r <= S_EM_RD;
            end
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_from_symbol = out_from_r;
  assign out_to_symbol   = out_to_r;
  assign out_pair_count  = out_cnt_r;
  assign out_intensity   = out_int_r;
  assign out_last        = out_last_r;

endmodule

// ----- hw/rtl/sth_checker.sv -----
// Port-level checks for the symbol transition histogram, bound to the top level.
// Depends on sth_pkg and symbol_transition_histogram.
module sth_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_operation,
  input logic                      out_strobe,
  input logic [sth_pkg::CNT_W-1:0] out_pair_count,
  input logic [sth_pkg::INT_W-1:0] out_intensity,
  input logic                      out_last
);
  import sth_pkg::*;

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_PUSH) |=> !busy)
    else $error("push request raised busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result outside a readout");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("readout ended before last entry");

  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back results");

  a_zero_int: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pair_count == '0) |-> out_intensity == '0)
    else $error("nonzero intensity for zero count");

endmodule

bind symbol_transition_histogram sth_checker u_sth_checker (.*);
